[rtl/sbce_pkg.sv]
// ----------------------------------------------------------------------------
// sbce_pkg: shared definitions for the byte-budget cache with age eviction
// Widths, result and operation codes, register index and the types that pass
// between the sequencer and the slot scan unit.
// ----------------------------------------------------------------------------
package sbce_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = SLOT_W + 1;

    localparam int TAG_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int BYTES_W  = 24;
    localparam int AGE_W    = 32;
    localparam int USED_W   = 25;
    localparam int KIND_W   = 3;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = '1;
    localparam logic [AGE_W-1:0]   AGE_ONE      = AGE_W'(1);
    localparam logic [AGE_W-1:0]   AGE_MAX      = '1;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EVICTED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFRESHED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd4;

    // Register index as decoded from paddr[2]
    localparam logic REG_BYTE_BUDGET = 1'b0;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic [AGE_W-1:0]    age;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctl_t;

    typedef struct packed {
        logic                match_found;
        logic [SLOT_W-1:0]   match_idx;
        logic [HANDLE_W-1:0] match_handle;
        logic                best_found;
        logic [SLOT_W-1:0]   best_idx;
        logic [TAG_W-1:0]    best_tag;
        logic [HANDLE_W-1:0] best_handle;
        logic [BYTES_W-1:0]  best_bytes;
        logic                free_found;
        logic [SLOT_W-1:0]   free_idx;
    } scan_res_t;

endpackage

[rtl/sbce_if.sv]
// ----------------------------------------------------------------------------
// sbce_if: request and result channels of the cache core
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface sbce_req_if ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [sbce_pkg::TAG_W-1:0]    key_tag;
    logic [sbce_pkg::HANDLE_W-1:0] value_handle;
    logic [sbce_pkg::BYTES_W-1:0]  content_bytes;

    modport source (
        output valid, func, key_tag, value_handle, content_bytes,
        input  ready
    );
    modport sink (
        input  valid, func, key_tag, value_handle, content_bytes,
        output ready
    );
endinterface

interface sbce_rsp_if ();
    logic                          valid;
    logic                          ready;
    logic [sbce_pkg::KIND_W-1:0]   kind;
    logic                          hit;
    logic [sbce_pkg::HANDLE_W-1:0] handle_out;
    logic [sbce_pkg::TAG_W-1:0]    tag_out;
    logic                          last;

    modport source (
        output valid, kind, hit, handle_out, tag_out, last,
        input  ready
    );
    modport sink (
        input  valid, kind, hit, handle_out, tag_out, last,
        output ready
    );
endinterface

[rtl/sbce_scan_unit.sv]
// ----------------------------------------------------------------------------
// sbce_scan_unit: shared compare unit for slot scans
// Sees one slot per cycle while eval is set and keeps the first tag match,
// the oldest valid slot (lowest index on equal ages) and the lowest free slot.
// ----------------------------------------------------------------------------
module sbce_scan_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbce_pkg::scan_ctl_t          ctl,
    input  logic [sbce_pkg::TAG_W-1:0]   key_tag,
    input  sbce_pkg::entry_t             entry,
    input  logic                         entry_valid,
    input  logic [sbce_pkg::SLOT_W-1:0]  entry_idx,
    output sbce_pkg::scan_res_t          res
);

    sbce_pkg::scan_res_t           res_reg;
    sbce_pkg::scan_res_t           res_next;
    logic [sbce_pkg::AGE_W-1:0]    best_age_reg;
    logic [sbce_pkg::AGE_W-1:0]    best_age_next;

    always_comb
    begin
        res_next      = res_reg;
        best_age_next = best_age_reg;
        priority if (ctl.clear)
        begin
            res_next.match_found = 1'b0;
            res_next.best_found  = 1'b0;
            res_next.free_found  = 1'b0;
        end
        else if (ctl.eval)
        begin
            if (entry_valid && entry.tag == key_tag && !res_reg.match_found)
            begin
                res_next.match_found  = 1'b1;
                res_next.match_idx    = entry_idx;
                res_next.match_handle = entry.handle;
            end
            // Strictly greater keeps the earlier slot on equal ages.
            if (entry_valid && (!res_reg.best_found || entry.age > best_age_reg))
            begin
                res_next.best_found  = 1'b1;
                res_next.best_idx    = entry_idx;
                res_next.best_tag    = entry.tag;
                res_next.best_handle = entry.handle;
                res_next.best_bytes  = entry.bytes;
                best_age_next        = entry.age;
            end
            if (!entry_valid && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = entry_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg.match_found <= 1'b0;
            res_reg.best_found  <= 1'b0;
            res_reg.free_found  <= 1'b0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_age_reg <= best_age_next;
    end

    assign res = res_reg;

endmodule

[rtl/size_budget_cache_age_evict_core.sv]
// ----------------------------------------------------------------------------
// size_budget_cache_age_evict_core: age-evicting object cache under a byte budget
// Sixteen slots of tag, handle, size and age in a slot memory, a sequencer and
// one shared scan unit; byte budget register on an APB-style port.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the core is idle.
// Every pass over the table reads one slot a cycle through the single read
// port of the slot memory. An insert of a present key takes two passes, as
// does an insert of a new key that needs no eviction. Each eviction adds one
// more pass and its decision steps, and waits while the output register is
// still full. A rejected insert takes one pass. The core returns to idle
// before it takes the next request. Results are held in an output register,
// so the next request may be taken while the last result still waits.
module size_budget_cache_age_evict_core (
    input  logic                          clk,
    input  logic                          rst_n,
    sbce_req_if.sink                      req,
    sbce_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbce_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbce_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbce_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;
    localparam logic [2:0] ST_AGE    = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    localparam int SUM_W = sbce_pkg::USED_W + 1;

    // Control state
    logic [2:0]                      state_reg, state_next;
    logic [sbce_pkg::BYTES_W-1:0]    budget_reg, budget_next;
    logic [sbce_pkg::USED_W-1:0]     used_reg, used_next;
    logic [sbce_pkg::SLOTS-1:0]      valid_reg, valid_next;
    logic [sbce_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic                            evicting_reg, evicting_next;
    logic                            out_valid_reg, out_valid_next;

    // Payload
    logic [sbce_pkg::SLOT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [sbce_pkg::SLOT_W-1:0]     skip_reg, skip_next;
    logic                            func_reg, func_next;
    logic [sbce_pkg::TAG_W-1:0]      key_reg, key_next;
    logic [sbce_pkg::HANDLE_W-1:0]   handle_reg, handle_next;
    logic [sbce_pkg::BYTES_W-1:0]    size_reg, size_next;
    logic [sbce_pkg::KIND_W-1:0]     pend_kind_reg, pend_kind_next;
    logic                            pend_hit_reg, pend_hit_next;
    logic [sbce_pkg::HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;
    logic [sbce_pkg::TAG_W-1:0]      pend_tag_reg, pend_tag_next;
    logic                            pend_last_reg, pend_last_next;
    logic [sbce_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic                            out_hit_reg, out_hit_next;
    logic [sbce_pkg::HANDLE_W-1:0]   out_handle_reg, out_handle_next;
    logic [sbce_pkg::TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic                            out_last_reg, out_last_next;

    // Slot memory
    sbce_pkg::entry_t                mem [sbce_pkg::SLOTS];
    sbce_pkg::entry_t                rd_data_reg;
    logic                            mem_we;
    logic [sbce_pkg::SLOT_W-1:0]     mem_waddr;
    sbce_pkg::entry_t                mem_wdata;

    sbce_pkg::scan_ctl_t             scan_ctl;
    sbce_pkg::scan_res_t             scan_res;

    logic                            issue;
    logic                            pass_done;
    logic                            over_budget;
    logic                            cfg_write;
    logic                            rd_slot_valid;

    sbce_scan_unit u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .key_tag     (key_reg),
        .entry       (rd_data_reg),
        .entry_valid (rd_slot_valid),
        .entry_idx   (rd_idx_reg),
        .res         (scan_res)
    );

    assign issue = (state_reg == ST_SCAN || state_reg == ST_AGE) &&
                   (cnt_reg < sbce_pkg::CNT_W'(sbce_pkg::SLOTS));
    assign pass_done = (cnt_reg == sbce_pkg::CNT_W'(sbce_pkg::SLOTS)) && !rd_pend_reg;
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign over_budget = ({1'b0, used_reg} + SUM_W'(size_reg)) >= SUM_W'(budget_reg);
    assign cfg_write = psel && penable && pwrite && (paddr[2] == sbce_pkg::REG_BYTE_BUDGET);

    always_comb
    begin
        state_next       = state_reg;
        budget_next      = budget_reg;
        used_next        = used_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        rd_pend_next     = issue;
        rd_idx_next      = cnt_reg[sbce_pkg::SLOT_W-1:0];
        evicting_next    = evicting_reg;
        out_valid_next   = out_valid_reg;
        skip_next        = skip_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        handle_next      = handle_reg;
        size_next        = size_reg;
        pend_kind_next   = pend_kind_reg;
        pend_hit_next    = pend_hit_reg;
        pend_handle_next = pend_handle_reg;
        pend_tag_next    = pend_tag_reg;
        pend_last_next   = pend_last_reg;
        out_kind_next    = out_kind_reg;
        out_hit_next     = out_hit_reg;
        out_handle_next  = out_handle_reg;
        out_tag_next     = out_tag_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = rd_idx_reg;
        mem_wdata        = rd_data_reg;
        scan_ctl         = '0;

        if (issue)
        begin
            cnt_next = cnt_reg + sbce_pkg::CNT_W'(1);
        end

        if (cfg_write)
        begin
            budget_next = pwdata[sbce_pkg::BYTES_W-1:0];
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = req.func;
                    key_next       = req.key_tag;
                    handle_next    = req.value_handle;
                    size_next      = req.content_bytes;
                    cnt_next       = '0;
                    evicting_next  = 1'b0;
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                scan_ctl.eval = rd_pend_reg;
                if (pass_done)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                pend_hit_next    = 1'b0;
                pend_handle_next = '0;
                pend_tag_next    = key_reg;
                pend_last_next   = 1'b1;
                priority if (evicting_reg)
                begin
                    state_next = ST_CHECK;
                end
                else if (func_reg == sbce_pkg::FUNC_LOOKUP)
                begin
                    pend_kind_next   = sbce_pkg::KIND_LOOKUP;
                    pend_hit_next    = scan_res.match_found;
                    pend_handle_next = scan_res.match_found ? scan_res.match_handle : '0;
                    state_next       = ST_EMIT;
                end
                else if (scan_res.match_found)
                begin
                    pend_kind_next = sbce_pkg::KIND_REFRESHED;
                    skip_next      = scan_res.match_idx;
                    cnt_next       = '0;
                    state_next     = ST_AGE;
                end
                else if (size_reg >= budget_reg)
                begin
                    pend_kind_next = sbce_pkg::KIND_REJECTED;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // An empty table ends the eviction loop even if still over budget.
                if ((over_budget || !scan_res.free_found) && scan_res.best_found)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_EVICT:
            begin
                pend_kind_next   = sbce_pkg::KIND_EVICTED;
                pend_hit_next    = 1'b0;
                pend_handle_next = scan_res.best_handle;
                pend_tag_next    = scan_res.best_tag;
                pend_last_next   = 1'b0;
                valid_next[scan_res.best_idx] = 1'b0;
                if (used_reg >= sbce_pkg::USED_W'(scan_res.best_bytes))
                begin
                    used_next = used_reg - sbce_pkg::USED_W'(scan_res.best_bytes);
                end
                else
                begin
                    used_next = '0;
                end
                evicting_next = 1'b1;
                state_next    = ST_EMIT;
            end

            ST_INSERT:
            begin
                mem_we           = 1'b1;
                mem_waddr        = scan_res.free_idx;
                mem_wdata.tag    = key_reg;
                mem_wdata.handle = handle_reg;
                mem_wdata.bytes  = size_reg;
                mem_wdata.age    = sbce_pkg::AGE_ONE;
                valid_next[scan_res.free_idx] = 1'b1;
                used_next      = used_reg + sbce_pkg::USED_W'(size_reg);
                skip_next      = scan_res.free_idx;
                pend_kind_next = sbce_pkg::KIND_INSERTED;
                pend_hit_next    = 1'b0;
                pend_handle_next = '0;
                pend_tag_next    = key_reg;
                pend_last_next   = 1'b1;
                cnt_next       = '0;
                state_next     = ST_AGE;
            end

            ST_AGE:
            begin
                // The touched slot goes to age one; every other valid slot ages.
                if (rd_pend_reg && rd_slot_valid)
                begin
                    mem_we = 1'b1;
                    if (rd_idx_reg == skip_reg)
                    begin
                        mem_wdata.age = sbce_pkg::AGE_ONE;
                    end
                    else if (rd_data_reg.age != sbce_pkg::AGE_MAX)
                    begin
                        mem_wdata.age = rd_data_reg.age + sbce_pkg::AGE_ONE;
                    end
                end
                if (pass_done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_hit_next    = pend_hit_reg;
                    out_handle_next = pend_handle_reg;
                    out_tag_next    = pend_tag_reg;
                    out_last_next   = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // After an eviction the oldest slot must be found again.
                        cnt_next       = '0;
                        scan_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            budget_reg    <= sbce_pkg::BUDGET_RESET;
            used_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            evicting_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            budget_reg    <= budget_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            evicting_reg  <= evicting_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        skip_reg        <= skip_next;
        func_reg        <= func_next;
        key_reg         <= key_next;
        handle_reg      <= handle_next;
        size_reg        <= size_next;
        pend_kind_reg   <= pend_kind_next;
        pend_hit_reg    <= pend_hit_next;
        pend_handle_reg <= pend_handle_next;
        pend_tag_reg    <= pend_tag_next;
        pend_last_reg   <= pend_last_next;
        out_kind_reg    <= out_kind_next;
        out_hit_reg     <= out_hit_next;
        out_handle_reg  <= out_handle_next;
        out_tag_reg     <= out_tag_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[cnt_reg[sbce_pkg::SLOT_W-1:0]];
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.tag_out    = out_tag_reg;
    assign rsp.last       = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sbce_pkg::REG_BYTE_BUDGET) ?
                    sbce_pkg::PDATA_W'(budget_reg) : '0;

endmodule
